/* rtl/core/dhe_pkg.sv */
// discrete hazard estimator: shared widths, opcodes and control structs
// no dependencies; every other file of the block uses this package
package dhe_pkg;

	// sizing of the histograms and the counts
	localparam int SLOTS     = 64;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int MAX_OBS   = 4096;
	localparam int CNT_W     = $clog2(MAX_OBS + 1);
	localparam int FRAC_BITS = 16;
	localparam int HAZ_W     = FRAC_BITS + 1;
	localparam int NUM_W     = CNT_W + FRAC_BITS;
	localparam int WORD_W    = 2 * CNT_W;

	localparam logic [SLOT_W-1:0] TIMES_RESET = SLOT_W'(SLOTS - 1);
	localparam logic [CNT_W-1:0]  OBS_FULL    = CNT_W'(MAX_OBS);
	localparam logic [HAZ_W-1:0]  HAZ_ONE     = {1'b1, {FRAC_BITS{1'b0}}};

	// input opcodes
	typedef enum logic {
		OP_ADD    = 1'b0,
		OP_FINISH = 1'b1
	} dhe_op_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic in_take;
		logic add_commit;
		logic fin_init;
		logic div_start;
		logic haz_zero;
		logic out_load;
	} dhe_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic in_finish;
		logic trivial;
		logic div_done;
		logic out_free;
		logic is_last;
	} dhe_stat_t;

endpackage

/* rtl/core/dhe_if.sv */
// discrete hazard estimator: valid/ready channel interfaces
// depends on dhe_pkg for the field widths

// observation and finish transactions
interface dhe_item_if;
	logic                          valid;
	logic                          ready;
	logic                          opcode;
	logic [dhe_pkg::SLOT_W-1:0]    time_index;
	logic                          failed;

	modport source (output valid, opcode, time_index, failed, input ready);
	modport sink (input valid, opcode, time_index, failed, output ready);
endinterface

// per-slot hazard results
interface dhe_result_if;
	logic                          valid;
	logic                          ready;
	logic [dhe_pkg::SLOT_W-1:0]    slot;
	logic [dhe_pkg::CNT_W-1:0]     failures;
	logic [dhe_pkg::CNT_W-1:0]     at_risk;
	logic [dhe_pkg::HAZ_W-1:0]     hazard;
	logic [dhe_pkg::CNT_W-1:0]     node_size;
	logic                          last;

	modport source (output valid, slot, failures, at_risk, hazard, node_size, last,
		input ready);
	modport sink (input valid, slot, failures, at_risk, hazard, node_size, last,
		output ready);
endinterface

// num_times register writes
interface dhe_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [dhe_pkg::SLOT_W-1:0]    num_times;

	modport source (output valid, num_times, input ready);
	modport sink (input valid, num_times, output ready);
endinterface

/* rtl/core/dhe_div.sv */
// discrete hazard estimator: bit-serial restoring divider, one quotient bit a cycle
// computes (dividend << FRAC_BITS) / divisor; depends on dhe_pkg
module dhe_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [dhe_pkg::CNT_W-1:0]   dividend,
	input  logic [dhe_pkg::CNT_W-1:0]   divisor,
	output logic                        done,
	output logic [dhe_pkg::HAZ_W-1:0]   quotient
);
	import dhe_pkg::*;

	localparam int STEP_W = $clog2(NUM_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [NUM_W-1:0]  num_q;
	logic [HAZ_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;

	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;
	logic              fits;

	// one trial subtraction per cycle while a division is in flight
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	// step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder, numerator and quotient shift registers
	// the quotient never exceeds one, so only its low HAZ_W bits are kept
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {dividend, {FRAC_BITS{1'b0}}};
			rem_q <= '0;
			quo_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_q <= {quo_q[HAZ_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	// no restart while a division is in flight
	assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("divider restarted while busy");

	// done is a single-cycle pulse
	assert property (@(posedge clk) disable iff (!arst_n) done_q |=> !done_q)
		else $error("divider done held longer than one cycle");

endmodule

/* rtl/core/dhe_dp.sv */
// discrete hazard estimator: datapath with histogram memory, risk counter and output register
// depends on dhe_pkg, dhe_if and dhe_div
module dhe_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_opcode,
	input  logic [dhe_pkg::SLOT_W-1:0]  item_time_index,
	input  logic                        item_failed,
	dhe_cfg_if.sink                     cfg,
	dhe_result_if.source                result,
	input  dhe_pkg::dhe_cmd_t           cmd,
	output dhe_pkg::dhe_stat_t          stat
);
	import dhe_pkg::*;

	// histogram memory, one word per slot: {failures, censors}
	logic [WORD_W-1:0] mem_q [SLOTS];
	logic [SLOTS-1:0]  vld_q;
	logic [WORD_W-1:0] rd_word_q;
	logic              rd_vld_q;

	logic [SLOT_W-1:0] num_times_q;
	logic [SLOT_W-1:0] tidx_q;
	logic              failed_q;
	logic [CNT_W-1:0]  obs_q;
	logic [CNT_W-1:0]  risk_q;
	logic [SLOT_W-1:0] slot_q;
	logic [HAZ_W-1:0]  hazard_q;

	logic              out_valid_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [CNT_W-1:0]  out_fail_q;
	logic [CNT_W-1:0]  out_risk_q;
	logic [HAZ_W-1:0]  out_haz_q;
	logic [CNT_W-1:0]  out_size_q;
	logic              out_last_q;

	logic              rd_en;
	logic [SLOT_W-1:0] rd_addr;
	logic              wr_en;
	logic [WORD_W-1:0] wr_word;
	logic [CNT_W-1:0]  cur_fail;
	logic [CNT_W-1:0]  cur_cens;
	logic [CNT_W:0]    sub;
	logic              active_slot;
	logic              out_free;
	logic              div_done;
	logic [HAZ_W-1:0]  div_quo;

	// entries not written since the last clear read as zero
	assign cur_fail = rd_vld_q ? rd_word_q[WORD_W-1:CNT_W] : '0;
	assign cur_cens = rd_vld_q ? rd_word_q[CNT_W-1:0] : '0;

	// read port: the incoming slot on an add, slot 0 on a finish, else the next walk slot
	assign rd_en   = cmd.in_take || cmd.out_load;
	assign rd_addr = cmd.in_take
		? ((dhe_op_t'(item_opcode) == OP_FINISH) ? '0 : item_time_index)
		: slot_q + 1'b1;

	// write back the incremented count unless the node is full
	assign wr_en   = cmd.add_commit && (obs_q != OBS_FULL);
	assign wr_word = failed_q ? {cur_fail + 1'b1, cur_cens} : {cur_fail, cur_cens + 1'b1};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[tidx_q] <= wr_word;
		end
		if (rd_en) begin
			rd_word_q <= mem_q[rd_addr];
		end
	end

	// valid bits, cleared at the end of a finish walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
			if (cmd.out_load && stat.is_last) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[tidx_q] <= 1'b1;
			end
		end
	end

	// configuration register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_times_q <= TIMES_RESET;
		end else if (cfg.valid) begin
			num_times_q <= cfg.num_times;
		end
	end

	// captured transaction fields
	always_ff @(posedge clk) begin
		if (cmd.in_take) begin
			tidx_q   <= item_time_index;
			failed_q <= item_failed;
		end
	end

	// slot counter of the walk and the slot's remaining risk
	assign active_slot = (slot_q != '0) && (risk_q != '0);
	assign sub         = {1'b0, cur_fail} + {1'b0, cur_cens};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obs_q  <= '0;
			risk_q <= '0;
			slot_q <= '0;
		end else begin
			if (wr_en) begin
				obs_q <= obs_q + 1'b1;
			end
			if (cmd.fin_init) begin
				risk_q <= obs_q - cur_cens;
				slot_q <= '0;
			end else if (cmd.out_load) begin
				slot_q <= slot_q + 1'b1;
				if (stat.is_last) begin
					obs_q  <= '0;
					risk_q <= '0;
				end else if (active_slot) begin
					risk_q <= (sub >= {1'b0, risk_q}) ? '0 : risk_q - sub[CNT_W-1:0];
				end
			end
		end
	end

	// hazard of the current slot
	dhe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (cur_fail),
		.divisor  (risk_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.haz_zero) begin
			hazard_q <= '0;
		end else if (div_done) begin
			hazard_q <= div_quo;
		end
	end

	// output register
	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_slot_q <= slot_q;
			out_fail_q <= cur_fail;
			out_risk_q <= risk_q;
			out_haz_q  <= hazard_q;
			out_size_q <= obs_q;
			out_last_q <= stat.is_last;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.slot      = out_slot_q;
	assign result.failures  = out_fail_q;
	assign result.at_risk   = out_risk_q;
	assign result.hazard    = out_haz_q;
	assign result.node_size = out_size_q;
	assign result.last      = out_last_q;

	// status to the controller
	assign stat.in_finish = dhe_op_t'(item_opcode) == OP_FINISH;
	assign stat.trivial   = !active_slot;
	assign stat.div_done  = div_done;
	assign stat.out_free  = out_free;
	assign stat.is_last   = slot_q == num_times_q;

	// a slot never holds more failures than are at risk
	assert property (@(posedge clk) disable iff (!arst_n) out_valid_q |-> out_haz_q <= HAZ_ONE)
		else $error("hazard above one");

	// a finished walk leaves the node empty
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && stat.is_last) |=> (obs_q == '0 && vld_q == '0))
		else $error("node not cleared after the last slot");

endmodule

/* rtl/core/dhe_ctrl.sv */
// discrete hazard estimator: sequencing state machine
// drives dhe_cmd_t, reads dhe_stat_t; depends on dhe_pkg
module dhe_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	output dhe_pkg::dhe_cmd_t    cmd,
	input  dhe_pkg::dhe_stat_t   stat
);
	import dhe_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_ADD  = 6'b000010,
		ST_FINI = 6'b000100,
		ST_EVAL = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_EMIT = 6'b100000
	} dhe_state_t;

	dhe_state_t state_q;
	dhe_state_t state_d;

	assign item_ready = state_q == ST_IDLE;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.in_take = 1'b1;
					state_d     = stat.in_finish ? ST_FINI : ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.add_commit = 1'b1;
				state_d        = ST_IDLE;
			end
			ST_FINI: begin
				cmd.fin_init = 1'b1;
				state_d      = ST_EVAL;
			end
			ST_EVAL: begin
				if (stat.trivial) begin
					cmd.haz_zero = 1'b1;
					state_d      = ST_EMIT;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				if (stat.div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = stat.is_last ? ST_IDLE : ST_EVAL;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// results only go into a free output register
	assert property (@(posedge clk) disable iff (!arst_n) cmd.out_load |-> stat.out_free)
		else $error("output register overwritten");

	// at most one command per cycle
	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(cmd))
		else $error("conflicting datapath commands");

	// an accepted transaction is either an add or a finish
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> (state_q == ST_ADD || state_q == ST_FINI))
		else $error("accepted transaction not dispatched");

endmodule

/* rtl/core/discrete_hazard_estimator_core.sv */
// discrete hazard estimator: top level joining controller and datapath
// depends on dhe_pkg, dhe_if, dhe_ctrl, dhe_dp and dhe_div

// An add transaction reads the histogram bin, then writes it back; no new
// transaction is taken before the write-back, and an add yields no result.
// A finish transaction reads slot 0, sets up the risk count and walks slots
// 0..num_times, emitting one result per slot: slot 0 and slots after the
// at-risk count has reached zero get a zero hazard, every other slot waits
// for the bit-serial divider, which makes one of the 29 quotient bits per
// cycle. Stalls on the result channel hold the walk. The histograms are
// emptied at once when the last slot is emitted, so the next node can start
// loading right after. num_times may be written at any time the block is idle.
module discrete_hazard_estimator_core (
	input  logic          clk,
	input  logic          arst_n,
	dhe_cfg_if.sink       cfg,
	dhe_item_if.sink      item,
	dhe_result_if.source  result
);
	import dhe_pkg::*;

	dhe_cmd_t  cmd;
	dhe_stat_t stat;

	// sequencing
	dhe_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.cmd        (cmd),
		.stat       (stat)
	);

	// histograms, risk counter, divider and output register
	dhe_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_opcode     (item.opcode),
		.item_time_index (item.time_index),
		.item_failed     (item.failed),
		.cfg             (cfg),
		.result          (result),
		.cmd             (cmd),
		.stat            (stat)
	);

endmodule

/* verif/testbench.sv */
// testbench for discrete_hazard_estimator_core: loads observation nodes, finishes
// them and checks every per-slot hazard transaction against its own predictor
// depends on dhe_pkg, dhe_if and the block's rtl
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import dhe_pkg::*;

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 8;
	localparam int RANDOM_ITEMS = 210;
	localparam int HOLD_CYCLES  = 400;
	localparam int TIMEOUT_NS   = 20_000_000;

	// one per-slot result as it leaves the block
	typedef struct {
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  failures;
		logic [CNT_W-1:0]  at_risk;
		logic [HAZ_W-1:0]  hazard;
		logic [CNT_W-1:0]  node_size;
		logic              last;
	} slot_hazard_t;

	// histogram predictor and store of expected slot results
	class hazard_scoreboard;
		int unsigned fail_hist[SLOTS];
		int unsigned cens_hist[SLOTS];
		int unsigned obs_count;
		logic [SLOT_W-1:0] top_slot;
		slot_hazard_t pending_hazards[$];
		int mismatches;
		int checked;
		int nodes;

		function new();
			clear_node();
			top_slot = TIMES_RESET;
			mismatches = 0;
			checked = 0;
			nodes = 0;
		endfunction

		function void clear_node();
			foreach (fail_hist[i]) begin
				fail_hist[i] = 0;
				cens_hist[i] = 0;
			end
			obs_count = 0;
		endfunction

		// an add bumps one bin; a finish walks the slots and queues their results
		function void note_item(dhe_op_t op, logic [SLOT_W-1:0] tidx, logic failed);
			int unsigned risk;
			int unsigned sub;
			int unsigned f;
			longint unsigned wide_f;
			longint unsigned quot;
			slot_hazard_t r;
			if (op == OP_ADD) begin
				// a full node drops further observations
				if (obs_count >= MAX_OBS)
					return;
				if (failed)
					fail_hist[tidx]++;
				else
					cens_hist[tidx]++;
				obs_count++;
				return;
			end
			// slot 0 censors leave the risk set before the walk starts
			risk = obs_count - cens_hist[0];
			for (int j = 0; j <= top_slot; j++) begin
				f = fail_hist[j];
				r.slot = SLOT_W'(j);
				r.failures = CNT_W'(f);
				r.at_risk = CNT_W'(risk);
				r.hazard = '0;
				r.node_size = CNT_W'(obs_count);
				r.last = (j == top_slot);
				if (j > 0 && risk > 0) begin
					wide_f = f;
					quot = (wide_f << FRAC_BITS) / risk;
					r.hazard = quot[HAZ_W-1:0];
					sub = f + cens_hist[j];
					risk = (sub >= risk) ? 0 : risk - sub;
				end
				pending_hazards.push_back(r);
			end
			nodes++;
			clear_node();
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			// keep the log readable when the block is badly broken
			if (mismatches <= 60)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want, int slot);
			if (got !== want)
				report_mismatch($sformatf("slot %0d %s got %0d want %0d",
					slot, name, got, want));
		endtask

		// compare one accepted result with the oldest expectation
		task check_result(slot_hazard_t got);
			slot_hazard_t want;
			checked++;
			if (pending_hazards.size() == 0) begin
				report_mismatch($sformatf("unexpected result transaction for slot %0d",
					got.slot));
				return;
			end
			want = pending_hazards.pop_front();
			compare_field("slot", got.slot, want.slot, want.slot);
			compare_field("failures", got.failures, want.failures, want.slot);
			compare_field("at_risk", got.at_risk, want.at_risk, want.slot);
			compare_field("hazard", got.hazard, want.hazard, want.slot);
			compare_field("node_size", got.node_size, want.node_size, want.slot);
			compare_field("last", got.last, want.last, want.slot);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dhe_cfg_if    cfg_ch();
	dhe_item_if   item_ch();
	dhe_result_if result_ch();

	hazard_scoreboard sb = new();

	bit tx_steady = 1'b0;
	int holds_asked = 0;
	int holds_done = 0;
	int random_items = 0;
	int obs_sent = 0;
	int cfg_writes = 0;
	int cfg_min = 63;
	int cfg_max = 0;

	discrete_hazard_estimator_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (result_ch)
	);

	always #HALF_PERIOD clk = ~clk;

	// offer one transaction after a random gap, or none in steady mode, and wait for its acceptance
	task automatic send_item(dhe_op_t op, logic [SLOT_W-1:0] tidx, logic failed);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.opcode <= op;
		item_ch.time_index <= tidx;
		item_ch.failed <= failed;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_item(op, tidx, failed);
		if (op == OP_ADD)
			obs_sent++;
	endtask

	// stop offering until every expected result has come back
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		while (sb.pending_hazards.size() != 0) @(posedge clk);
		// an add may still be writing back its histogram bin
		repeat (6) @(posedge clk);
	endtask

	task automatic write_num_times(logic [SLOT_W-1:0] v);
		wait_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.num_times <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		sb.top_slot = v;
		cfg_writes++;
		if (v < cfg_min)
			cfg_min = v;
		if (v > cfg_max)
			cfg_max = v;
	endtask

	// mostly slots inside the walk, some at slot 0, some anywhere in the slot range
	function automatic logic [SLOT_W-1:0] pick_slot();
		int k;
		k = $urandom_range(0, 9);
		if (k < 1)
			return '0;
		if (k < 8)
			return SLOT_W'($urandom_range(0, sb.top_slot));
		return SLOT_W'($urandom_range(0, SLOTS - 1));
	endfunction

	task automatic run_directed();
		// empty node under the reset walk length: every slot reports zeros
		send_item(OP_FINISH, '0, 1'b0);
		// walk of slot zero alone
		write_num_times(SLOT_W'(0));
		send_item(OP_ADD, SLOT_W'(0), 1'b1);
		send_item(OP_ADD, SLOT_W'(0), 1'b0);
		send_item(OP_FINISH, SLOT_W'(63), 1'b1);
		// full walk touching both ends of the slot range
		write_num_times(SLOT_W'(63));
		send_item(OP_ADD, SLOT_W'(1), 1'b1);
		send_item(OP_ADD, SLOT_W'(1), 1'b0);
		send_item(OP_ADD, SLOT_W'(63), 1'b1);
		send_item(OP_ADD, SLOT_W'(0), 1'b0);
		send_item(OP_ADD, SLOT_W'(5), 1'b1);
		send_item(OP_ADD, SLOT_W'(5), 1'b1);
		send_item(OP_FINISH, SLOT_W'(0), 1'b0);
		// walk of slots 0 and 1; an observation past the walk stays in the risk set
		write_num_times(SLOT_W'(1));
		send_item(OP_ADD, SLOT_W'(1), 1'b1);
		send_item(OP_ADD, SLOT_W'(2), 1'b1);
		send_item(OP_FINISH, SLOT_W'(0), 1'b0);
		// risk set runs out before the walk ends
		write_num_times(SLOT_W'(10));
		send_item(OP_ADD, SLOT_W'(3), 1'b1);
		send_item(OP_ADD, SLOT_W'(3), 1'b0);
		send_item(OP_ADD, SLOT_W'(7), 1'b1);
		send_item(OP_FINISH, SLOT_W'(0), 1'b0);
	endtask

	// nodes of random observations, each closed by a finish
	task automatic run_random();
		int node_obs;
		int node_idx;
		int top;
		node_idx = 0;
		while (random_items < RANDOM_ITEMS) begin
			// new walk length now and then, short walks most often
			// the node after the held walk is offered without a pause
			if (node_idx != 3 && $urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 3))
					0: top = 1;
					1: top = 63;
					2: top = $urandom_range(2, 8);
					default: top = $urandom_range(1, 63);
				endcase
				write_num_times(SLOT_W'(top));
			end else if (node_idx % 5 == 4) begin
				wait_idle();
			end
			tx_steady = ($urandom_range(0, 3) == 0);
			node_obs = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 25);
			repeat (node_obs) begin
				send_item(OP_ADD, pick_slot(), $urandom_range(0, 9) < 6);
				random_items++;
			end
			send_item(OP_FINISH, SLOT_W'($urandom), 1'($urandom));
			random_items++;
			// stall the results during this walk while the next node keeps coming
			if (node_idx == 2)
				holds_asked++;
			node_idx++;
		end
		tx_steady = 1'b0;
	endtask

	// result side: random stalls, steady stretches and one long hold
	initial begin : result_sink
		int stall;
		int hold_left;
		bit steady;
		slot_hazard_t got;
		stall = 0;
		hold_left = 0;
		steady = 1'b0;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				got.slot = result_ch.slot;
				got.failures = result_ch.failures;
				got.at_risk = result_ch.at_risk;
				got.hazard = result_ch.hazard;
				got.node_size = result_ch.node_size;
				got.last = result_ch.last;
				sb.check_result(got);
				stall = steady ? 0 : $urandom_range(0, 5);
				if ($urandom_range(0, 39) == 0)
					steady = !steady;
			end
			if (holds_done < holds_asked) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// reset, stimulus and final verdict
	initial begin : stimulus
		item_ch.valid <= 1'b0;
		item_ch.opcode <= OP_ADD;
		item_ch.time_index <= '0;
		item_ch.failed <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.num_times <= TIMES_RESET;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		wait_idle();
		repeat (40) @(posedge clk);
		$display("covered %0d nodes from %0d observations, %0d slot results checked",
			sb.nodes, obs_sent, sb.checked);
		$display("walk length set %0d times over %0d..%0d, results held off for %0d cycles once",
			cfg_writes, cfg_min, cfg_max, HOLD_CYCLES);
		if (sb.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// hard stop if the block hangs
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("timeout with %0d slot results outstanding", sb.pending_hazards.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/dhe_pkg.sv
rtl/core/dhe_if.sv
rtl/core/dhe_div.sv
rtl/core/dhe_dp.sv
rtl/core/dhe_ctrl.sv
rtl/core/discrete_hazard_estimator_core.sv
verif/testbench.sv
